[hdl/rtpc_pkg.sv]
// Shared types and constants for the TCP port packet capture block.
// Used by all rtpc modules.
package rtpc_pkg;

	localparam int CAPTURE_BYTES = 120;
	localparam int OUTQ_DEPTH = 8;

	localparam logic [15:0] CAPTURE_PORT_RST = 16'd6379;

	localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
	localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
	localparam logic [15:0] OFF_IP_PROTO = 16'd23;
	localparam logic [15:0] OFF_SPORT_HI = 16'd34;
	localparam logic [15:0] OFF_SPORT_LO = 16'd35;
	localparam logic [15:0] OFF_DPORT_HI = 16'd36;
	localparam logic [15:0] OFF_DPORT_LO = 16'd37;
	localparam logic [15:0] PAYLOAD_START = 16'd54;
	localparam logic [15:0] PAYLOAD_END = 16'(54 + CAPTURE_BYTES);
	localparam logic [15:0] OFF_MAX = 16'hFFFF;

	localparam logic [7:0] ETYPE_HI = 8'h08;
	localparam logic [7:0] ETYPE_LO = 8'h00;
	localparam logic [7:0] PROTO_TCP = 8'd6;

	localparam logic [7:0] MK_PLUS = 8'h2B;
	localparam logic [7:0] MK_MINUS = 8'h2D;
	localparam logic [7:0] MK_COLON = 8'h3A;
	localparam logic [7:0] MK_DOLLAR = 8'h24;
	localparam logic [7:0] MK_STAR = 8'h2A;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;
	localparam logic DIR_IN = 1'b0;
	localparam logic DIR_OUT = 1'b1;

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  payload_byte;
		logic [6:0]  payload_index;
		logic [15:0] frame_size;
		logic        direction;
		logic        record_last;
	} rtpc_rec_t;

	typedef struct packed {
		logic      v0;
		rtpc_rec_t r0;
		logic      v1;
		rtpc_rec_t r1;
	} rtpc_push_t;

	function automatic logic is_marker(input logic [7:0] b);
		return b inside {MK_PLUS, MK_MINUS, MK_COLON, MK_DOLLAR, MK_STAR};
	endfunction

endpackage

[hdl/rtpc_if.sv]
// Request channel interfaces: frame input, record output, config write.
// No dependencies.
interface rtpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;
	modport source (output valid, frame_byte, frame_last, input ready);
	modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

interface rtpc_out_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [7:0]  payload_byte;
	logic [6:0]  payload_index;
	logic [15:0] frame_size;
	logic        direction;
	logic        record_last;
	modport source (output valid, record_kind, payload_byte, payload_index, frame_size,
		direction, record_last, input ready);
	modport sink (input valid, record_kind, payload_byte, payload_index, frame_size,
		direction, record_last, output ready);
endinterface

interface rtpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] capture_port;
	modport source (output valid, capture_port, input ready);
	modport sink (input valid, capture_port, output ready);
endinterface

[hdl/rtpc_parser.sv]
// Frame parser: input register, header checks, port match, record build.
// Depends on rtpc_pkg and rtpc_in_if.
module rtpc_parser
	import rtpc_pkg::*;
#(
	parameter int OUTQ_DEPTH = rtpc_pkg::OUTQ_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rtpc_in_if.sink                        in_ch,
	input  logic [15:0]                    capture_port,
	input  logic [$clog2(OUTQ_DEPTH+1)-1:0] free,
	output rtpc_push_t                     push
);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic [15:0] off_q;
	logic        hm_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;
	logic        dir_q;
	logic        cap_q;

	logic        hm_n;
	logic [15:0] src_n;
	logic [15:0] dst_n;
	logic        dir_n;
	logic        cap_n;
	logic        in_win;
	logic        emit;
	logic        summ;
	rtpc_rec_t   rec_byte;
	rtpc_rec_t   rec_sum;
	logic        accept;

	// room for the request in flight plus a new one, two records each
	assign in_ch.ready = v_s1 ? (free >= CW'(4)) : (free >= CW'(2));
	assign accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_ch.frame_byte;
			last_s1 <= in_ch.frame_last;
		end
	end

	always_comb begin
		hm_n = hm_q;
		src_n = src_q;
		dst_n = dst_q;
		dir_n = dir_q;
		case (off_q)
			OFF_ETYPE_HI: begin
				if (byte_s1 != ETYPE_HI) hm_n = 1'b0;
			end
			OFF_ETYPE_LO: begin
				if (byte_s1 != ETYPE_LO) hm_n = 1'b0;
			end
			OFF_IP_PROTO: begin
				if (byte_s1 != PROTO_TCP) hm_n = 1'b0;
			end
			OFF_SPORT_HI: src_n = {byte_s1, 8'h00};
			OFF_SPORT_LO: src_n = {src_q[15:8], byte_s1};
			OFF_DPORT_HI: dst_n = {byte_s1, 8'h00};
			OFF_DPORT_LO: begin
				dst_n = {dst_q[15:8], byte_s1};
				if (dst_n == capture_port) dir_n = DIR_IN;
				else if (src_q == capture_port) dir_n = DIR_OUT;
				else hm_n = 1'b0;
			end
			default: ;
		endcase
	end

	assign cap_n = cap_q || (off_q == PAYLOAD_START && hm_n && is_marker(byte_s1));
	assign in_win = (off_q >= PAYLOAD_START) && (off_q < PAYLOAD_END);
	assign emit = v_s1 && cap_n && in_win;
	assign summ = v_s1 && last_s1 && cap_n;

	always_comb begin
		rec_byte.record_kind = KIND_PAYLOAD;
		rec_byte.payload_byte = byte_s1;
		rec_byte.payload_index = 7'(off_q - PAYLOAD_START);
		rec_byte.frame_size = '0;
		rec_byte.direction = dir_n;
		rec_byte.record_last = !last_s1;

		rec_sum.record_kind = KIND_SUMMARY;
		rec_sum.payload_byte = '0;
		rec_sum.payload_index = '0;
		rec_sum.frame_size = (off_q == OFF_MAX) ? OFF_MAX : off_q + 16'd1;
		rec_sum.direction = dir_n;
		rec_sum.record_last = 1'b1;
	end

	always_comb begin
		push.v0 = emit || summ;
		push.r0 = emit ? rec_byte : rec_sum;
		push.v1 = emit && summ;
		push.r1 = rec_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			hm_q <= 1'b1;
			src_q <= '0;
			dst_q <= '0;
			dir_q <= DIR_IN;
			cap_q <= 1'b0;
		end else if (v_s1) begin
			if (last_s1) begin
				off_q <= '0;
				hm_q <= 1'b1;
				src_q <= '0;
				dst_q <= '0;
				dir_q <= DIR_IN;
				cap_q <= 1'b0;
			end else begin
				if (off_q != OFF_MAX) off_q <= off_q + 16'd1;
				hm_q <= hm_n;
				src_q <= src_n;
				dst_q <= dst_n;
				dir_q <= dir_n;
				cap_q <= cap_n;
			end
		end
	end

	a_second_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && push.r0.record_kind == KIND_PAYLOAD
			&& push.r1.record_kind == KIND_SUMMARY)
		else $error("second record is not a summary after a payload byte");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 && push.r0.record_kind == KIND_PAYLOAD
			|-> push.r0.payload_index < 7'(CAPTURE_BYTES))
		else $error("payload index beyond capture window");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && last_s1 |=> off_q == '0 && !cap_q && hm_q)
		else $error("frame state not cleared after last byte");

endmodule

[hdl/rtpc_outq.sv]
// Record queue: two writes per cycle, one read, feeds the output channel.
// Depends on rtpc_pkg and rtpc_out_if.
module rtpc_outq
	import rtpc_pkg::*;
#(
	parameter int DEPTH = rtpc_pkg::OUTQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rtpc_push_t                 push,
	rtpc_out_if.source                 out_ch,
	output logic [$clog2(DEPTH+1)-1:0] free
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

	rtpc_rec_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     wr_ptr1;
	logic [CW-1:0]     npush;
	logic              pop;
	rtpc_rec_t         head;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == LAST_P) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr1 = inc(wr_ptr_q);
	assign npush = CW'(push.v0) + CW'(push.v1);
	assign pop = out_ch.valid && out_ch.ready;
	assign free = CW'(DEPTH) - cnt_q;

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_ptr_q] <= push.r0;
		if (push.v1) mem_q[wr_ptr1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.v1) wr_ptr_q <= inc(wr_ptr1);
			else if (push.v0) wr_ptr_q <= wr_ptr1;
			if (pop) rd_ptr_q <= inc(rd_ptr_q);
			cnt_q <= cnt_q + npush - CW'(pop);
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign out_ch.valid = (cnt_q != '0);
	assign out_ch.record_kind = head.record_kind;
	assign out_ch.payload_byte = head.payload_byte;
	assign out_ch.payload_index = head.payload_index;
	assign out_ch.frame_size = head.frame_size;
	assign out_ch.direction = head.direction;
	assign out_ch.record_last = head.record_last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		npush <= free)
		else $error("record queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 && !pop |=> cnt_q != '0)
		else $error("queue count lost a push");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");

endmodule

[hdl/resp_tcp_port_packet_capture_unit.sv]
// Top level of the TCP port packet capture block: config register,
// parser and record queue. Depends on rtpc_pkg, rtpc_if, rtpc_parser, rtpc_outq.
//
// Usage:
//   in_ch  : one Ethernet frame byte per request, frame_last marks the end.
//   out_ch : capture records. Kind 0 carries a payload byte of a frame whose
//            destination or source TCP port matches capture_port and whose
//            first payload byte is a command marker; kind 1 is the summary
//            with frame size and direction, sent after the last byte.
//   cfg_ch : writes capture_port (reset value 6379); always ready. Write only
//            while no frame is in progress.
// A record passes through the parser input register and the record queue
// before it is valid on out_ch. Throughput: one input byte per cycle while
// in_ch is not stalled; a final byte inside the capture window makes two
// records, taken one at a time from the queue.
// The parser register and a record queue of OUTQ_DEPTH entries set this:
// in_ch stalls only when the queue lacks room for two records per byte
// still in flight, so a stalled receiver backs up into in_ch after a few
// bytes. Reset clears all frame state and empties the queue.
module resp_tcp_port_packet_capture_unit
	import rtpc_pkg::*;
#(
	parameter int OUTQ_DEPTH = rtpc_pkg::OUTQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	rtpc_in_if.sink    in_ch,
	rtpc_out_if.source out_ch,
	rtpc_cfg_if.sink   cfg_ch
);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	logic [15:0]   capture_port_q;
	logic [CW-1:0] free;
	rtpc_push_t    push;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_port_q <= CAPTURE_PORT_RST;
		end else if (cfg_ch.valid) begin
			capture_port_q <= cfg_ch.capture_port;
		end
	end

	rtpc_parser #(
		.OUTQ_DEPTH(OUTQ_DEPTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.capture_port(capture_port_q),
		.free(free),
		.push(push)
	);

	rtpc_outq #(
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.out_ch(out_ch),
		.free(free)
	);

endmodule
